// ===== rtl/glyph_cache_shelf_atlas_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the glyph cache shelf atlas allocator
// Clocked property checks with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_CACHE_SHELF_ATLAS_ALLOCATOR_ASSERT_SVH
`define GLYPH_CACHE_SHELF_ATLAS_ALLOCATOR_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define GCSA_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error(msg);

// Check that a condition never holds outside reset.
`define GCSA_NEVER(lbl, clk_i, rst_ni, cond, msg) \
	`GCSA_ASSERT(lbl, clk_i, rst_ni, !(cond), msg)

`endif

// ===== rtl/gcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gcsa_pkg
// Shared constants, codes and types of the glyph cache shelf atlas allocator.
// ----------------------------------------------------------------------------
package gcsa_pkg;

	localparam int ATLAS_DIM     = 512;
	localparam int CACHE_ENTRIES = 256;

	localparam int CODE_W = 11;
	localparam int POS_W  = 9;
	localparam int SIZE_W = 8;
	localparam int IDX_W  = $clog2(CACHE_ENTRIES);
	// cursor holds values up to ATLAS_DIM itself
	localparam int CUR_W  = $clog2(ATLAS_DIM) + 1;
	localparam int SUM_W  = ((CUR_W > SIZE_W + 1) ? CUR_W : SIZE_W + 1) + 1;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	localparam logic [IDX_W-1:0] FOLD_CODE = IDX_W'(63);

	localparam logic [1:0] STATUS_ABSENT  = 2'd0;
	localparam logic [1:0] STATUS_IMAGE   = 2'd1;
	localparam logic [1:0] STATUS_NOIMAGE = 2'd2;

	typedef enum logic [1:0] {
		KIND_UNLOADED = 2'd0,
		KIND_IMAGE    = 2'd1,
		KIND_NOIMAGE  = 2'd2,
		KIND_ABSENT   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [SIZE_W-1:0]  w;
		logic [SIZE_W-1:0]  h;
	} entry_t;

	typedef struct packed {
		logic latch;
		logic rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ===== rtl/gcsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcsa_ctrl
// Request sequencer: accept, cache read, evaluate and commit.
// ----------------------------------------------------------------------------
module gcsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  gcsa_pkg::status_t status,
	output gcsa_pkg::cmd_t    cmd
);
	import gcsa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic   tready_q;
	logic   accept;

	assign s_axis_tready = tready_q;
	assign accept        = s_axis_tvalid && tready_q;

	assign cmd.latch  = accept;
	assign cmd.rd     = (state_q == ST_READ);
	assign cmd.commit = (state_q == ST_EVAL) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q  <= ST_READ;
						tready_q <= 1'b0;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					// hold until the result register can take the beat
					if (status.out_free) begin
						state_q  <= ST_IDLE;
						tready_q <= 1'b1;
					end
				end
				default: begin
					state_q  <= ST_IDLE;
					tready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== rtl/gcsa_datapath.sv =====
// ----------------------------------------------------------------------------
// gcsa_datapath
// Glyph cache store, shelf packing cursor and result register.
// ----------------------------------------------------------------------------
module gcsa_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gcsa_pkg::cmd_t                       cmd,
	output gcsa_pkg::status_t                    status,
	input  logic [gcsa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [gcsa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import gcsa_pkg::*;

	// request fields
	logic [CODE_W-1:0] in_code;
	logic              in_present;
	logic [SIZE_W-1:0] in_w;
	logic [SIZE_W-1:0] in_h;

	assign in_code    = s_axis_tdata[CODE_W-1:0];
	assign in_present = s_axis_tdata[CODE_W];
	assign in_w       = s_axis_tdata[CODE_W+SIZE_W:CODE_W+1];
	assign in_h       = s_axis_tdata[CODE_W+2*SIZE_W:CODE_W+SIZE_W+1];

	logic [IDX_W-1:0]  addr_s1;
	logic              present_s1;
	logic [SIZE_W-1:0] w_s1;
	logic [SIZE_W-1:0] h_s1;

	entry_t mem [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;
	entry_t rd_s2;
	logic   hit_s2;

	logic [CUR_W-1:0]  cursor_x_q;
	logic [CUR_W-1:0]  cursor_y_q;
	logic [SIZE_W-1:0] shelf_q;

	logic                   out_valid_q;
	logic [1:0]             out_status_q;
	logic                   out_cached_q;
	logic [POS_W-1:0]       out_x_q;
	logic [POS_W-1:0]       out_y_q;
	logic [SIZE_W-1:0]      out_w_q;
	logic [SIZE_W-1:0]      out_h_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			// codes beyond the cache fold to '?'
			if (in_code >= CODE_W'(CACHE_ENTRIES))
				addr_s1 <= FOLD_CODE;
			else
				addr_s1 <= in_code[IDX_W-1:0];
			present_s1 <= in_present;
			w_s1       <= in_w;
			h_s1       <= in_h;
		end
	end

	// shelf packer
	logic [SUM_W-1:0]  sum_x;
	logic              wrap;
	logic [SUM_W-1:0]  cy_wrap;
	logic [CUR_W-1:0]  cx_eff;
	logic [CUR_W-1:0]  cy_eff;
	logic [SIZE_W-1:0] shelf_eff;
	logic [SUM_W-1:0]  sum_y;
	logic              full;
	logic              sized;
	entry_t            new_entry;
	entry_t            res_entry;

	always_comb begin
		sum_x   = SUM_W'(cursor_x_q) + SUM_W'(w_s1) + SUM_W'(1);
		wrap    = sum_x > SUM_W'(ATLAS_DIM);
		cy_wrap = SUM_W'(cursor_y_q) + SUM_W'(shelf_q) + SUM_W'(1);
		if (wrap) begin
			cx_eff    = CUR_W'(1);
			// past the bottom edge nothing fits again, so saturate
			cy_eff    = (cy_wrap > SUM_W'(ATLAS_DIM)) ? CUR_W'(ATLAS_DIM)
				: cy_wrap[CUR_W-1:0];
			shelf_eff = '0;
		end else begin
			cx_eff    = cursor_x_q;
			cy_eff    = cursor_y_q;
			shelf_eff = shelf_q;
		end
		sum_y = SUM_W'(cy_eff) + SUM_W'(h_s1) + SUM_W'(1);
		full  = sum_y > SUM_W'(ATLAS_DIM);
		sized = present_s1 && (w_s1 != '0) && (h_s1 != '0);

		new_entry = '{kind: KIND_ABSENT, x: '0, y: '0, w: '0, h: '0};
		if (present_s1) begin
			if (!sized) begin
				new_entry.kind = KIND_NOIMAGE;
				new_entry.w    = w_s1;
				new_entry.h    = h_s1;
			end else if (full) begin
				new_entry.kind = KIND_NOIMAGE;
			end else begin
				new_entry.kind = KIND_IMAGE;
				new_entry.x    = cx_eff[POS_W-1:0];
				new_entry.y    = cy_eff[POS_W-1:0];
				new_entry.w    = w_s1;
				new_entry.h    = h_s1;
			end
		end
		res_entry = hit_s2 ? rd_s2 : new_entry;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd)
			rd_s2 <= mem[addr_s1];
		if (cmd.commit && !hit_s2)
			mem[addr_s1] <= new_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			hit_s2     <= 1'b0;
			cursor_x_q <= CUR_W'(1);
			cursor_y_q <= CUR_W'(1);
			shelf_q    <= '0;
		end else begin
			if (cmd.rd)
				hit_s2 <= valid_q[addr_s1];
			if (cmd.commit && !hit_s2) begin
				valid_q[addr_s1] <= 1'b1;
				if (sized) begin
					cursor_y_q <= cy_eff;
					if (full) begin
						cursor_x_q <= cx_eff;
						shelf_q    <= shelf_eff;
					end else begin
						cursor_x_q <= cx_eff + CUR_W'(w_s1) + CUR_W'(1);
						shelf_q    <= (h_s1 > shelf_eff) ? h_s1 : shelf_eff;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			unique case (res_entry.kind)
				KIND_IMAGE:   out_status_q <= STATUS_IMAGE;
				KIND_NOIMAGE: out_status_q <= STATUS_NOIMAGE;
				default:      out_status_q <= STATUS_ABSENT;
			endcase
			out_cached_q <= hit_s2;
			out_x_q      <= res_entry.x;
			out_y_q      <= res_entry.y;
			out_w_q      <= res_entry.w;
			out_h_q      <= res_entry.h;
		end
	end

	assign status.out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {3'b000, out_h_q, out_w_q, out_y_q, out_x_q,
		out_cached_q, out_status_q};

endmodule

// ===== rtl/glyph_cache_shelf_atlas_allocator.sv =====
// ----------------------------------------------------------------------------
// glyph_cache_shelf_atlas_allocator
// Glyph cache with a shelf packer that places missed glyphs in a square atlas.
// ----------------------------------------------------------------------------
// Flow: an accepted request beat is latched, the cache store is read into a
// register, and the evaluate-and-write step loads the result register on m_axis.
// A new request is taken only after the previous one has written its result;
// a stalled result register holds the evaluate step until the beat is taken.
// Reset: arst_n clears all cache valid bits at once (every glyph unloaded),
// sets the packing cursor to (1,1) with an empty shelf, and empties m_axis.
module glyph_cache_shelf_atlas_allocator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// char_code[10:0], glyph_present[11], glyph_width[19:12],
	// glyph_height[27:20], zero[31:28]
	input  logic [gcsa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// glyph_status[1:0], was_cached[2], atlas_x[11:3], atlas_y[20:12],
	// placed_width[28:21], placed_height[36:29], zero[39:37]
	output logic [gcsa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import gcsa_pkg::*;

	cmd_t    cmd;
	status_t status;

	gcsa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	gcsa_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== rtl/gcsa_checker.sv =====
// ----------------------------------------------------------------------------
// gcsa_checker
// Port-level checks of the glyph cache shelf atlas allocator.
// ----------------------------------------------------------------------------
`include "glyph_cache_shelf_atlas_allocator_assert.svh"

module gcsa_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic [gcsa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [gcsa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import gcsa_pkg::*;

	logic in_beat;
	logic in_pad_zero;
	logic in_taken;
	logic out_stall;
	logic bad_status;
	logic absent_beat;
	logic absent_clean;

	assign in_beat      = s_axis_tvalid && s_axis_tready;
	assign in_pad_zero  = (s_axis_tdata[IN_TDATA_W-1:28] == '0);
	assign in_taken     = in_beat && in_pad_zero;
	assign out_stall    = m_axis_tvalid && !m_axis_tready;
	assign bad_status   = m_axis_tvalid && (m_axis_tdata[1:0] > STATUS_NOIMAGE);
	assign absent_beat  = m_axis_tvalid && (m_axis_tdata[1:0] == STATUS_ABSENT);
	assign absent_clean = (m_axis_tdata[36:3] == '0);

	`GCSA_ASSERT(a_out_hold, clk, arst_n, out_stall |=> m_axis_tvalid, "result beat dropped")
	`GCSA_ASSERT(a_one_at_a_time, clk, arst_n, in_taken |=> !s_axis_tready, "request overlap")
	`GCSA_NEVER(a_status_code, clk, arst_n, bad_status, "undefined glyph status")
	`GCSA_ASSERT(a_absent_zero, clk, arst_n, absent_beat |-> absent_clean, "absent glyph not zero")

endmodule

bind glyph_cache_shelf_atlas_allocator gcsa_checker u_gcsa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/glyph_cache_shelf_atlas_allocator_test.sv =====
// ----------------------------------------------------------------------------
// glyph_cache_shelf_atlas_allocator_test
// Drives glyph requests into the allocator and checks every result beat
// against a cycle-free model of the glyph cache and shelf packer. A directed
// table covers the hit/miss/fold/zero-size/atlas-full cases; random requests
// then pack the atlas until full, both sides idling at random but in a calm tail.
// ----------------------------------------------------------------------------
module glyph_cache_shelf_atlas_allocator_test;
	import gcsa_pkg::*;

	typedef struct packed {
		logic [3:0]        pad;
		logic [SIZE_W-1:0] h;
		logic [SIZE_W-1:0] w;
		logic              present;
		logic [CODE_W-1:0] code;
	} glyph_req_t;

	typedef struct packed {
		logic [2:0]        pad;
		logic [SIZE_W-1:0] h;
		logic [SIZE_W-1:0] w;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  x;
		logic              cached;
		logic [1:0]        status;
	} glyph_res_t;

	typedef struct {
		glyph_req_t req;
		bit         typed;
		glyph_res_t res;
	} plan_row_t;

	localparam int RANDOM_REQS = 1250;
	localparam int CALM_REQS   = 150;
	localparam int LONG_HOLD   = 150;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// shadow of the cache store and the packing cursor
	kind_t             slot_kind [CACHE_ENTRIES];
	logic [POS_W-1:0]  slot_x [CACHE_ENTRIES];
	logic [POS_W-1:0]  slot_y [CACHE_ENTRIES];
	logic [SIZE_W-1:0] slot_w [CACHE_ENTRIES];
	logic [SIZE_W-1:0] slot_h [CACHE_ENTRIES];
	int                pack_x;
	int                pack_y;
	int                shelf_h;

	glyph_res_t pending_results [$];
	int         mismatches;
	bit         calm_phase;

	glyph_cache_shelf_atlas_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#6000000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic glyph_req_t mk_req(int code, bit present, int w, int h);
		glyph_req_t r;
		r = '0;
		r.code = CODE_W'(code);
		r.present = present;
		r.w = SIZE_W'(w);
		r.h = SIZE_W'(h);
		return r;
	endfunction

	function automatic glyph_res_t mk_res(logic [1:0] status, bit cached, int x, int y,
			int w, int h);
		glyph_res_t r;
		r = '0;
		r.status = status;
		r.cached = cached;
		r.x = POS_W'(x);
		r.y = POS_W'(y);
		r.w = SIZE_W'(w);
		r.h = SIZE_W'(h);
		return r;
	endfunction

	// Look up one glyph, loading and packing it on a miss.
	function automatic glyph_res_t lookup_glyph(glyph_req_t r);
		glyph_res_t o;
		int         s;
		bit         hit;
		s = (r.code >= CACHE_ENTRIES) ? int'(FOLD_CODE) : int'(r.code);
		hit = slot_kind[s] != KIND_UNLOADED;
		if (!hit) begin
			slot_x[s] = '0;
			slot_y[s] = '0;
			slot_w[s] = '0;
			slot_h[s] = '0;
			if (!r.present) begin
				slot_kind[s] = KIND_ABSENT;
			end else begin
				slot_w[s] = r.w;
				slot_h[s] = r.h;
				if (r.w == 0 || r.h == 0) begin
					slot_kind[s] = KIND_NOIMAGE;
				end else begin
					// wrap to a new shelf; it stays even if the glyph then misses
					if (pack_x + int'(r.w) + 1 > ATLAS_DIM) begin
						pack_x = 1;
						pack_y += shelf_h + 1;
						shelf_h = 0;
					end
					if (pack_y + int'(r.h) + 1 > ATLAS_DIM) begin
						slot_w[s] = '0;
						slot_h[s] = '0;
						slot_kind[s] = KIND_NOIMAGE;
					end else begin
						slot_x[s] = POS_W'(pack_x);
						slot_y[s] = POS_W'(pack_y);
						slot_kind[s] = KIND_IMAGE;
						pack_x += int'(r.w) + 1;
						if (int'(r.h) > shelf_h)
							shelf_h = int'(r.h);
					end
				end
			end
		end
		o = '0;
		case (slot_kind[s])
			KIND_IMAGE:   o.status = STATUS_IMAGE;
			KIND_NOIMAGE: o.status = STATUS_NOIMAGE;
			default:      o.status = STATUS_ABSENT;
		endcase
		o.cached = hit;
		o.x = slot_x[s];
		o.y = slot_y[s];
		o.w = slot_w[s];
		o.h = slot_h[s];
		return o;
	endfunction

	function automatic glyph_req_t rand_req();
		int code;
		int w;
		int h;
		case ($urandom_range(0, 7))
			0, 1, 2, 3: code = $urandom_range(0, CACHE_ENTRIES - 1);
			4:          code = $urandom_range(CACHE_ENTRIES, 2047);
			5:          code = $urandom_range(0, 2047);
			default:    code = $urandom_range(0, 31);
		endcase
		case ($urandom_range(0, 15))
			0: begin
				w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 255);
				h = (w == 0) ? $urandom_range(0, 255) : 0;
			end
			1, 2, 3: begin
				w = $urandom_range(100, 255);
				h = $urandom_range(100, 255);
			end
			4: begin
				w = $urandom_range(0, 255);
				h = $urandom_range(0, 255);
			end
			default: begin
				w = $urandom_range(1, 40);
				h = $urandom_range(1, 40);
			end
		endcase
		return mk_req(code, $urandom_range(0, 9) != 0, w, h);
	endfunction

	// Offer one request, predict on acceptance, then maybe idle.
	task automatic offer(glyph_req_t r, bit typed, glyph_res_t typed_res);
		glyph_res_t p;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= r;
		do @(posedge clk); while (!s_axis_tready);
		p = lookup_glyph(r);
		pending_results.push_back(typed ? typed_res : p);
		if (!calm_phase && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic check_field(string what, int want_v, int got_v);
		if (want_v != got_v) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin : result_check
		glyph_res_t got;
		glyph_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = glyph_res_t'(m_axis_tdata);
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none actual %h", $time,
					m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("glyph_status", want.status, got.status);
				check_field("was_cached", want.cached, got.cached);
				check_field("atlas_x", want.x, got.x);
				check_field("atlas_y", want.y, got.y);
				check_field("placed_width", want.w, got.w);
				check_field("placed_height", want.h, got.h);
			end
		end
	end

	// Result side: random stalls, one long hold-off to back up the block.
	initial begin : result_sink
		int n;
		int cyc;
		bit held;
		m_axis_tready = 1'b0;
		cyc = 0;
		held = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held && cyc >= 400) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				cyc += LONG_HOLD;
			end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 8);
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
				cyc += n;
			end else begin
				n = calm_phase ? 1 : $urandom_range(1, 12);
				m_axis_tready <= 1'b1;
				repeat (n) @(posedge clk);
				cyc += n;
			end
		end
	end

	initial begin : request_source
		plan_row_t  plan [$];
		glyph_res_t none;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		mismatches = 0;
		calm_phase = 1'b0;
		none = '0;
		pack_x = 1;
		pack_y = 1;
		shelf_h = 0;
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			slot_kind[i] = KIND_UNLOADED;
			slot_x[i] = '0;
			slot_y[i] = '0;
			slot_w[i] = '0;
			slot_h[i] = '0;
		end

		// largest glyph lands at (1,1), then hits ignore the new size
		plan.push_back('{mk_req(65, 1, 255, 255), 1,
			mk_res(STATUS_IMAGE, 0, 1, 1, 255, 255)});
		plan.push_back('{mk_req(65, 0, 0, 0), 1,
			mk_res(STATUS_IMAGE, 1, 1, 1, 255, 255)});
		// absent glyph stays absent
		plan.push_back('{mk_req(0, 0, 255, 255), 1, mk_res(STATUS_ABSENT, 0, 0, 0, 0, 0)});
		plan.push_back('{mk_req(0, 1, 12, 12), 1, mk_res(STATUS_ABSENT, 1, 0, 0, 0, 0)});
		// zero-size glyphs take no space
		plan.push_back('{mk_req(255, 1, 0, 200), 1,
			mk_res(STATUS_NOIMAGE, 0, 0, 0, 0, 200)});
		plan.push_back('{mk_req(254, 1, 17, 0), 1,
			mk_res(STATUS_NOIMAGE, 0, 0, 0, 17, 0)});
		plan.push_back('{mk_req(253, 1, 0, 0), 1, mk_res(STATUS_NOIMAGE, 0, 0, 0, 0, 0)});
		// high codes fold onto '?'
		plan.push_back('{mk_req(2047, 1, 1, 1), 0, none});
		plan.push_back('{mk_req(63, 1, 9, 9), 0, none});
		plan.push_back('{mk_req(256, 0, 0, 0), 0, none});
		plan.push_back('{mk_req(1024, 1, 200, 3), 0, none});
		// wrap onto the second shelf
		plan.push_back('{mk_req(1, 1, 253, 10), 0, none});
		// too tall for the space left: cached without image
		plan.push_back('{mk_req(2, 1, 1, 255), 1, mk_res(STATUS_NOIMAGE, 0, 0, 0, 0, 0)});
		plan.push_back('{mk_req(2, 1, 5, 5), 1, mk_res(STATUS_NOIMAGE, 1, 0, 0, 0, 0)});
		plan.push_back('{mk_req(3, 1, 255, 1), 0, none});
		plan.push_back('{mk_req(4, 1, 1, 1), 0, none});
		plan.push_back('{mk_req(6, 1, 255, 2), 0, none});
		// wrap, then miss vertically: the wrap must stick for the next glyph
		plan.push_back('{mk_req(7, 1, 255, 250), 0, none});
		plan.push_back('{mk_req(8, 1, 4, 4), 0, none});
		plan.push_back('{mk_req(128, 1, 170, 85), 0, none});

		@(posedge arst_n);
		@(posedge clk);
		foreach (plan[i])
			offer(plan[i].req, plan[i].typed, plan[i].res);
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == RANDOM_REQS - CALM_REQS)
				calm_phase = 1'b1;
			offer(rand_req(), 1'b0, none);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== glyph_cache_shelf_atlas_allocator.f =====
+incdir+rtl
rtl/gcsa_pkg.sv
rtl/gcsa_ctrl.sv
rtl/gcsa_datapath.sv
rtl/glyph_cache_shelf_atlas_allocator.sv
rtl/gcsa_checker.sv
tb/glyph_cache_shelf_atlas_allocator_test.sv
